>>> rtl/lrud_pkg.sv
package lrud_pkg;

	localparam int DATASET_W = 16;
	localparam int TILE_W = 32;
	localparam int RANK_W = 8;
	localparam int OCC_W = 9;
	localparam int CAP_W = 9;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd200;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// Request word.
	typedef struct packed {
		logic mode;
		logic [DATASET_W-1:0] dataset_id;
		logic [TILE_W-1:0] tile_id;
	} lrud_in_t;

	// Result word.
	typedef struct packed {
		logic hit;
		logic [RANK_W-1:0] rank;
		logic evicted;
		logic [DATASET_W-1:0] evicted_dataset;
		logic [TILE_W-1:0] evicted_tile;
		logic [OCC_W-1:0] occupancy;
	} lrud_out_t;

	// Per-cell control from the directory controller.
	typedef struct packed {
		logic cmp;
		logic valid;
		logic shift;
	} lrud_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPD
	} state_t;

endpackage

>>> rtl/lrud_cell.sv
module lrud_cell #(
	parameter int KEY_W = 48
) (
	input logic clk,
	input logic arst_n,
	input lrud_pkg::lrud_ctrl_t ctrl,
	input logic [KEY_W-1:0] req_key,
	input logic [KEY_W-1:0] prev_key,
	output logic [KEY_W-1:0] key,
	output logic match
);

	logic [KEY_W-1:0] key_q;
	logic match_q;

	// The key shifts in from the next newer rank when this rank moves back.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= prev_key;
		end
	end

	// Only ranks below the entry count take part in the compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.cmp) begin
			match_q <= ctrl.valid && (key_q == req_key);
		end
	end

	assign key = key_q;
	assign match = match_q;

endmodule

>>> rtl/lru_tile_cache_directory_core.sv
// Fully associative tile-key directory with least-recently-used replacement.
// Requests arrive on the in channel (in_valid/in_ready/in_data); each word is
// a (dataset_id, tile_id) key with a mode bit, where clear mode empties the
// directory. Every request produces exactly one result word on the out
// channel (out_valid/out_ready/out_data): hit flag and former rank, evicted
// flag and key, and the occupancy after the request.
// The keys live in a row of identical cells, one per recency rank. On the
// accept edge every cell compares its key against the request in parallel.
// In the update state, once the output register is free, the single match is
// encoded into a rank and, for a lookup, all cells at or below the shift
// limit take their newer neighbor's key, with rank 0 loading the request key.
// A new word is accepted only once the previous request has left its update
// state. The result sits in an output register, so a new word is accepted
// while the previous result still waits. If the receiver stalls with a
// result held, the next request waits in its update cycle and the cells do
// not move. Reset empties the directory (entry count zero) and sets capacity
// to 200. The capacity register is written through cfg_we/cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
module lru_tile_cache_directory_core #(
	parameter int MAX_ENTRIES = 256,
	parameter int DATASET_BITS = 16,
	parameter int TILE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lrud_pkg::lrud_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output lrud_pkg::lrud_out_t out_data,
	input logic cfg_we,
	input logic [lrud_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int KEY_W = DATASET_BITS + TILE_BITS;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > lrud_pkg::CAP_W) ? CNT_W : lrud_pkg::CAP_W;
	localparam int DS_EXT_W = DATASET_BITS + lrud_pkg::DATASET_W;
	localparam int TL_EXT_W = TILE_BITS + lrud_pkg::TILE_W;

	lrud_pkg::state_t state_q, state_d;

	logic [lrud_pkg::CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic req_mode_q;
	logic [KEY_W-1:0] req_key_q;
	logic out_valid_q;
	lrud_pkg::lrud_out_t out_q, result;

	logic in_fire, upd_fire;
	logic [KEY_W-1:0] in_key;
	logic [DATASET_BITS-1:0] in_ds;
	logic [TILE_BITS-1:0] in_tl;
	logic [DS_EXT_W-1:0] in_ds_ext;
	logic [TL_EXT_W-1:0] in_tl_ext;

	logic [KEY_W-1:0] cell_key [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] match_vec;
	lrud_pkg::lrud_ctrl_t cell_ctrl [MAX_ENTRIES];

	logic hit;
	logic [IDX_W-1:0] pos;
	logic [IDX_W+7:0] pos_ext;
	logic [CMP_W-1:0] cap_raw, cap_eff, count_ext;
	logic full;
	logic [CNT_W-1:0] oldest, limit;
	logic [KEY_W-1:0] ev_key;
	logic [DS_EXT_W-1:0] ev_ds_ext;
	logic [TL_EXT_W-1:0] ev_tl_ext;
	logic [CNT_W+8:0] occ_ext;

	// Keys narrower than the port fields keep only their low bits.
	assign in_ds_ext = {{DATASET_BITS{1'b0}}, in_data.dataset_id};
	assign in_tl_ext = {{TILE_BITS{1'b0}}, in_data.tile_id};
	assign in_ds = in_ds_ext[DATASET_BITS-1:0];
	assign in_tl = in_tl_ext[TILE_BITS-1:0];
	assign in_key = {in_ds, in_tl};

	assign in_ready = (state_q == lrud_pkg::ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign upd_fire = (state_q == lrud_pkg::ST_UPD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lrud_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_mode_q <= in_data.mode;
			req_key_q <= in_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrud_pkg::ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			out_q <= result;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lrud_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = lrud_pkg::ST_UPD;
				end
			end
			lrud_pkg::ST_UPD: begin
				if (upd_fire) begin
					state_d = lrud_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrud_pkg::ST_IDLE;
			end
		endcase
	end

	// Stored keys are unique among the valid ranks, so at most one cell
	// matches and the rank is a plain OR over the matching indexes.
	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match_vec[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end
	assign hit = |match_vec;
	assign pos_ext = {8'b0, pos};

	// Effective capacity is clamped into one to the number of cells.
	assign cap_raw = CMP_W'(capacity_q);
	assign count_ext = CMP_W'(count_q);
	always_comb begin
		if (cap_raw == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_raw > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_raw;
		end
	end
	assign full = (count_ext >= cap_eff);
	assign oldest = count_q - CNT_W'(1);

	// Key of the oldest valid rank, picked by a one-hot AND-OR.
	always_comb begin
		ev_key = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (CNT_W'(i) == oldest) begin
				ev_key = ev_key | cell_key[i];
			end
		end
	end
	assign ev_ds_ext = {{lrud_pkg::DATASET_W{1'b0}}, ev_key[KEY_W-1:TILE_BITS]};
	assign ev_tl_ext = {{lrud_pkg::TILE_W{1'b0}}, ev_key[TILE_BITS-1:0]};

	// Ranks up to the limit move back one; rank 0 takes the request key.
	always_comb begin
		if (hit) begin
			limit = CNT_W'(pos);
		end else if (full) begin
			limit = oldest;
		end else begin
			limit = count_q;
		end
	end

	always_comb begin
		count_d = count_q;
		result = '0;
		if (upd_fire) begin
			if (req_mode_q == lrud_pkg::MODE_CLEAR) begin
				count_d = '0;
			end else begin
				result.hit = hit;
				if (hit) begin
					if (pos_ext > (IDX_W + 8)'(255)) begin
						result.rank = 8'hFF;
					end else begin
						result.rank = pos_ext[7:0];
					end
				end else if (full) begin
					result.evicted = 1'b1;
					result.evicted_dataset = ev_ds_ext[lrud_pkg::DATASET_W-1:0];
					result.evicted_tile = ev_tl_ext[lrud_pkg::TILE_W-1:0];
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			occ_ext = {9'b0, count_d};
			if (occ_ext > (CNT_W + 9)'(511)) begin
				result.occupancy = 9'h1FF;
			end else begin
				result.occupancy = occ_ext[8:0];
			end
		end else begin
			occ_ext = '0;
		end
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [KEY_W-1:0] prev_key;

		if (i == 0) begin : g_head
			assign prev_key = req_key_q;
		end else begin : g_body
			assign prev_key = cell_key[i-1];
		end

		assign cell_ctrl[i].cmp = in_fire;
		assign cell_ctrl[i].valid = (CNT_W'(i) < count_q);
		assign cell_ctrl[i].shift = upd_fire && (req_mode_q == lrud_pkg::MODE_LOOKUP)
			&& (CNT_W'(i) <= limit);

		lrud_cell #(
			.KEY_W(KEY_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(cell_ctrl[i]),
			.req_key(in_key),
			.prev_key(prev_key),
			.key(cell_key[i]),
			.match(match_vec[i])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// The directory never holds more keys than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count exceeds number of cells");

	// A key is stored at most once among the valid ranks.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrud_pkg::ST_UPD) |-> $onehot0(match_vec))
		else $error("more than one cell matched the request key");

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.hit && out_q.evicted))
		else $error("result reports hit and eviction together");

	// An accepted request always moves on to its update cycle.
	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == lrud_pkg::ST_UPD))
		else $error("accepted request did not enter update");

	// Occupancy grows by at most one per lookup.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_fire && (req_mode_q == lrud_pkg::MODE_LOOKUP))
		|=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count changed by more than one");

endmodule
